/* design/sharpen_3x3_pixel_stream_assert.svh */
// ----------------------------------------------------------------------------
// sharpen_3x3_pixel_stream_assert
// assertion macros shared by the sharpen filter rtl
// ----------------------------------------------------------------------------
`ifndef SHARPEN_3X3_PIXEL_STREAM_ASSERT_SVH
`define SHARPEN_3X3_PIXEL_STREAM_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SHARPEN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SHARPEN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/sharpen_pkg.sv */
// ----------------------------------------------------------------------------
// sharpen_pkg
// constants, mask weights and arithmetic helpers of the 3x3 sharpen filter
// ----------------------------------------------------------------------------
package sharpen_pkg;

  localparam int PIX_W      = 8;
  localparam int DIM_W      = 10;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  localparam logic [MODE_W-1:0] MASK_MODE_RST    = 3'd1;
  localparam logic [DIM_W-1:0]  IMAGE_WIDTH_RST  = 10'd512;
  localparam logic [DIM_W-1:0]  IMAGE_HEIGHT_RST = 10'd512;

  // mask modes
  localparam logic [MODE_W-1:0] MODE_CROSS  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FULL   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DIAG   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_HP     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_HP_OFS = 3'd5;

  localparam int SUM_W       = 13;
  localparam int HP_OFFSET   = 1152;
  // x/9 == (x*3641)>>15 exactly for x < 8192
  localparam int RECIP_W     = 12;
  localparam int RECIP_9     = 3641;
  localparam int RECIP_SHIFT = 15;
  localparam int PIX_MAX     = 255;

  localparam int FIFO_DEPTH = 8;

  typedef logic [3*PIX_W-1:0] col_t;  // top, middle, bottom
  typedef logic signed [SUM_W-1:0] sum_t;

  localparam logic signed [4:0] MASK_W [4][9] = '{
    '{ 5'sd0, -5'sd1,  5'sd0, -5'sd1,  5'sd5, -5'sd1,  5'sd0, -5'sd1,  5'sd0},
    '{-5'sd1, -5'sd1, -5'sd1, -5'sd1,  5'sd9, -5'sd1, -5'sd1, -5'sd1, -5'sd1},
    '{ 5'sd1, -5'sd2,  5'sd1, -5'sd2,  5'sd5, -5'sd2,  5'sd1, -5'sd2,  5'sd1},
    '{-5'sd1, -5'sd1, -5'sd1, -5'sd1,  5'sd8, -5'sd1, -5'sd1, -5'sd1, -5'sd1}
  };

  function automatic logic [1:0] mask_sel(input logic [MODE_W-1:0] mode);
    logic [1:0] sel;
    case (mode)
      MODE_CROSS: sel = 2'd0;
      MODE_FULL:  sel = 2'd1;
      MODE_DIAG:  sel = 2'd2;
      default:    sel = 2'd3;
    endcase
    return sel;
  endfunction

  function automatic sum_t weighted_sum(input col_t lft, input col_t ctr, input col_t rgt,
                                        input logic [1:0] sel);
    col_t            cols [3];
    sum_t            acc;
    logic [PIX_W-1:0] p;
    cols[0] = lft;
    cols[1] = ctr;
    cols[2] = rgt;
    acc = '0;
    for (int m = 0; m < 3; m++) begin
      for (int n = 0; n < 3; n++) begin
        p   = cols[n][(2 - m) * PIX_W +: PIX_W];
        acc = acc + signed'(SUM_W'(p)) * SUM_W'(MASK_W[sel][m * 3 + n]);
      end
    end
    return acc;
  endfunction

  // rounding: half up for non-negative high-pass sums, toward zero for magnitudes
  function automatic logic [PIX_W-1:0] scale_byte(input sum_t s, input logic [MODE_W-1:0] mode);
    sum_t                       t;
    logic                       div9;
    logic                       known;
    logic [SUM_W-1:0]           x;
    logic [SUM_W+RECIP_W-1:0]   prod;
    logic [SUM_W-1:0]           q;
    logic [PIX_W-1:0]           res;
    case (mode)
      MODE_CROSS, MODE_FULL, MODE_DIAG: begin
        div9  = 1'b0;
        known = 1'b1;
      end
      MODE_HP, MODE_HP_OFS: begin
        div9  = 1'b1;
        known = 1'b1;
      end
      default: begin
        div9  = 1'b0;
        known = 1'b0;
      end
    endcase
    t = (mode == MODE_HP_OFS) ? s + sum_t'(HP_OFFSET) : s;
    if (t < 0) begin
      x = SUM_W'(-t);
    end else if (div9) begin
      x = SUM_W'(t + sum_t'(4));
    end else begin
      x = SUM_W'(t);
    end
    prod = (SUM_W+RECIP_W)'(x) * (SUM_W+RECIP_W)'(RECIP_9);
    q    = div9 ? SUM_W'(prod >> RECIP_SHIFT) : x;
    if (!known) begin
      res = '0;
    end else if (q > SUM_W'(PIX_MAX)) begin
      res = PIX_W'(PIX_MAX);
    end else begin
      res = q[PIX_W-1:0];
    end
    return res;
  endfunction

endpackage

/* design/sharpen_ram.sv */
// ----------------------------------------------------------------------------
// sharpen_ram
// single port write, single port read ram with registered read data
// ----------------------------------------------------------------------------
module sharpen_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/sharpen_3x3_pixel_stream.sv */
// ----------------------------------------------------------------------------
// sharpen_3x3_pixel_stream
// 3x3 sharpen / high-pass filter over a raster pixel stream, zero padded
// ----------------------------------------------------------------------------
// channel | direction | handshake         | payload
// in_     | input     | in_valid/in_stall   | in_pixel_in[7:0], in_drain
// out_    | output    | out_valid/out_stall | out_pixel_out[7:0], out_last_pixel
// cfg_    | input     | cfg_valid/cfg_ready | cfg_index[1:0], cfg_data[9:0]
//
// one item per clock while in_stall is low; its results pass the line ram read
// with window sum, then scaling, before they enter the output queue. the last
// item of a row gives two results and the first item of the next row none, so
// with out_stall low the input never stalls; it stalls only when the 8 entry
// queue lacks room for the results in flight plus two for the new item. the
// two line buffers share one ram with a registered read; a read of the entry
// written in the same cycle is forwarded. reset is synchronous; no ram clearing
// pass is needed.
// ----------------------------------------------------------------------------
`include "sharpen_3x3_pixel_stream_assert.svh"

module sharpen_3x3_pixel_stream #(
  parameter int MAX_WIDTH  = sharpen_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sharpen_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [sharpen_pkg::PIX_W-1:0]       in_pixel_in,
  input  logic                                in_drain,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sharpen_pkg::PIX_W-1:0]       out_pixel_out,
  output logic                                out_last_pixel,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sharpen_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sharpen_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import sharpen_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int RW    = $clog2(MAX_HEIGHT + 1);
  localparam int WEW   = ((WW > DIM_W) ? WW : DIM_W) + 1;
  localparam int HEW   = ((RW > DIM_W) ? RW : DIM_W) + 1;
  localparam int PW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int RAM_W = 2 * PIX_W;

  // configuration
  logic [MODE_W-1:0] mask_mode_r;
  logic [DIM_W-1:0]  image_width_r;
  logic [DIM_W-1:0]  image_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_mode_r    <= MASK_MODE_RST;
      image_width_r  <= IMAGE_WIDTH_RST;
      image_height_r <= IMAGE_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MASK_MODE:    mask_mode_r    <= cfg_data[MODE_W-1:0];
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // position tracking at acceptance
  logic            in_accept;
  logic [CW-1:0]   col_r, col_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic [WEW-1:0]  w_eff, col_inc;
  logic [HEW-1:0]  h_eff;
  logic            eor, drain_row;
  logic [PIX_W-1:0] bot;

  always_comb begin
    if (image_width_r == '0) begin
      w_eff = WEW'(1);
    end else if (WEW'(image_width_r) > WEW'(MAX_WIDTH)) begin
      w_eff = WEW'(MAX_WIDTH);
    end else begin
      w_eff = WEW'(image_width_r);
    end
    if (image_height_r == '0) begin
      h_eff = HEW'(1);
    end else if (HEW'(image_height_r) > HEW'(MAX_HEIGHT)) begin
      h_eff = HEW'(MAX_HEIGHT);
    end else begin
      h_eff = HEW'(image_height_r);
    end
    col_inc   = WEW'(col_r) + WEW'(1);
    eor       = col_inc >= w_eff;
    drain_row = HEW'(row_r) >= h_eff;
    bot       = (in_drain || drain_row) ? '0 : in_pixel_in;
    if (eor) begin
      col_nxt = '0;
      row_nxt = drain_row ? '0 : row_r + RW'(1);
    end else begin
      col_nxt = col_r + CW'(1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage 1: line ram data arrives
  logic             s1_valid_r;
  logic [CW-1:0]    s1_col_r;
  logic [PIX_W-1:0] s1_bot_r;
  logic             s1_ge1_r, s1_ge2_r, s1_first_r, s1_eor_r, s1_drain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_accept;
    end
    s1_col_r   <= col_r;
    s1_bot_r   <= bot;
    s1_ge1_r   <= row_r != '0;
    s1_ge2_r   <= row_r >= RW'(2);
    s1_first_r <= col_r == '0;
    s1_eor_r   <= eor;
    s1_drain_r <= drain_row;
  end

  logic             ram_we;
  logic [RAM_W-1:0] ram_wdata, ram_rdata, line_rd;
  logic             fwd_hit_r;
  logic [RAM_W-1:0] fwd_data_r;
  logic [PIX_W-1:0] top, mid;
  col_t             fresh, w0e, w1e;
  col_t             win0_r, win1_r;
  logic             emit_a, emit_b;
  sum_t             sum_a, sum_b;

  // ram word: line two above in the high byte, line one above in the low byte
  assign ram_we    = s1_valid_r;
  assign ram_wdata = {mid, s1_bot_r};

  sharpen_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_col_r),
    .wdata (ram_wdata),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  // width of one: the same entry is read while it is written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else begin
      fwd_hit_r <= ram_we && in_accept && (s1_col_r == col_r);
    end
    fwd_data_r <= ram_wdata;
  end

  always_comb begin
    line_rd = fwd_hit_r ? fwd_data_r : ram_rdata;
    top     = s1_ge2_r ? line_rd[RAM_W-1:PIX_W] : '0;
    mid     = s1_ge1_r ? line_rd[PIX_W-1:0] : '0;
    fresh   = {top, mid, s1_bot_r};
    w0e     = s1_first_r ? '0 : win0_r;
    w1e     = s1_first_r ? '0 : win1_r;
    emit_a  = s1_valid_r && s1_ge1_r && !s1_first_r;
    emit_b  = s1_valid_r && s1_ge1_r && s1_eor_r;
    sum_a   = weighted_sum(w0e, w1e, fresh, mask_sel(mask_mode_r));
    sum_b   = weighted_sum(w1e, fresh, '0, mask_sel(mask_mode_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win0_r <= '0;
      win1_r <= '0;
    end else if (s1_valid_r) begin
      win0_r <= w1e;
      win1_r <= fresh;
    end
  end

  // stage 2: scaling, then into the output queue
  logic s2_emit_a_r, s2_emit_b_r, s2_last_r;
  sum_t s2_sum_a_r, s2_sum_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_emit_a_r <= 1'b0;
      s2_emit_b_r <= 1'b0;
    end else begin
      s2_emit_a_r <= emit_a;
      s2_emit_b_r <= emit_b;
    end
    s2_sum_a_r <= sum_a;
    s2_sum_b_r <= sum_b;
    s2_last_r  <= s1_drain_r;
  end

  logic [PIX_W-1:0] pix_a, pix_b;

  assign pix_a = scale_byte(s2_sum_a_r, mask_mode_r);
  assign pix_b = scale_byte(s2_sum_b_r, mask_mode_r);

  // output queue, up to two writes and one read per cycle
  logic [PIX_W-1:0] fifo_pix_r  [FIFO_DEPTH];
  logic             fifo_last_r [FIFO_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt, wr_ptr_b, rd_ptr_r;
  logic [CNT_W-1:0] fifo_count_r, fifo_count_nxt;
  logic [CNT_W:0]   pending;
  logic             pop;

  assign pop        = out_valid && !out_stall;
  assign wr_ptr_b   = wr_ptr_r + PW'(s2_emit_a_r);
  assign wr_ptr_nxt = wr_ptr_b + PW'(s2_emit_b_r);
  assign fifo_count_nxt = fifo_count_r + CNT_W'(s2_emit_a_r) + CNT_W'(s2_emit_b_r)
                          - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (s2_emit_a_r) begin
      fifo_pix_r[wr_ptr_r]  <= pix_a;
      fifo_last_r[wr_ptr_r] <= 1'b0;
    end
    if (s2_emit_b_r) begin
      fifo_pix_r[wr_ptr_b]  <= pix_b;
      fifo_last_r[wr_ptr_b] <= s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      fifo_count_r <= '0;
    end else begin
      wr_ptr_r     <= wr_ptr_nxt;
      fifo_count_r <= fifo_count_nxt;
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
    end
  end

  assign out_valid      = fifo_count_r != '0;
  assign out_pixel_out  = fifo_pix_r[rd_ptr_r];
  assign out_last_pixel = fifo_last_r[rd_ptr_r];

  // credit: room for the queue, the results in flight and two for the new item
  assign pending   = (CNT_W+1)'(fifo_count_r)
                     + (CNT_W+1)'(emit_a) + (CNT_W+1)'(emit_b)
                     + (CNT_W+1)'(s2_emit_a_r) + (CNT_W+1)'(s2_emit_b_r);
  assign in_stall  = (pending + (CNT_W+1)'(2)) > (CNT_W+1)'(FIFO_DEPTH);
  assign in_accept = in_valid && !in_stall;

  `SHARPEN_ASSERT_IMP(fifo_bound_a, 1'b1, fifo_count_r <= CNT_W'(FIFO_DEPTH), "output queue overflow")
  `SHARPEN_ASSERT_IMP(fwd_owner_a, fwd_hit_r, s1_valid_r, "forward hit without an item in stage 1")
  `SHARPEN_ASSERT_NEXT(wrap_a, in_accept && eor && drain_row, (row_r == '0) && (col_r == '0), "position did not wrap after drain row")
  `SHARPEN_ASSERT_IMP(last_emit_a, s1_valid_r && s1_drain_r && s1_eor_r, emit_b, "final pixel of image not emitted")

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for sharpen_3x3_pixel_stream: raster frames of random
// geometry and texture go in under random idle and stall, every filtered
// pixel is predicted in the bench and compared in order on arrival
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sharpen_pkg::*;

  localparam int ITEM_TARGET    = 900;
  localparam int WHOLE_FRAME    = 1 << 20;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_CAP     = 100;
  localparam int MAX_WAIT       = 18;

  // mode values that select no mask
  localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

  typedef struct packed {
    bit [PIX_W-1:0] pix;
    bit             drain;
  } pixel_item_t;

  typedef struct packed {
    bit [PIX_W-1:0] pix;
    bit             last;
  } pixel_result_t;

  typedef enum {TEXTURE_NOISE, TEXTURE_BINARY, TEXTURE_FLAT} texture_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PIX_W-1:0]      in_pixel_in = '0;
  logic                  in_drain = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PIX_W-1:0]      out_pixel_out;
  logic                  out_last_pixel;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sharpen_3x3_pixel_stream uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_in    (in_pixel_in),
    .in_drain       (in_drain),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_out  (out_pixel_out),
    .out_last_pixel (out_last_pixel),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // bench copy of the filter state and registers
  bit [MODE_W-1:0] mask_mode_reg = MASK_MODE_RST;
  bit [DIM_W-1:0]  width_reg     = IMAGE_WIDTH_RST;
  bit [DIM_W-1:0]  height_reg    = IMAGE_HEIGHT_RST;
  bit [PIX_W-1:0]  line_one [MAX_WIDTH_DEF];
  bit [PIX_W-1:0]  line_two [MAX_WIDTH_DEF];
  bit [3*PIX_W-1:0] win_left, win_ctr;
  int              col_pos, row_pos;

  // position of the next queued item, tracked on the stimulus side
  int              gen_col, gen_row;
  int              queued_total;

  pixel_item_t     pending_pixels [$];
  pixel_result_t   expected_pixels [$];

  bit              in_taken, out_taken;
  int              in_wait, out_wait;
  bit              sender_steady, receiver_steady;
  int              quiet_cycles;
  int              fail_count, items_in, results_seen, frames_done;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int eff_dim(input bit [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return v;
  endfunction

  function automatic int draw_wait(input bit steady);
    if (steady) return 0;
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_WAIT) : $urandom_range(0, 1);
  endfunction

  function automatic bit [PIX_W-1:0] filter_pixel(input bit [3*PIX_W-1:0] lft,
                                                  input bit [3*PIX_W-1:0] ctr,
                                                  input bit [3*PIX_W-1:0] rgt);
    int               wt [9];
    int               acc;
    int               q;
    bit [3*PIX_W-1:0] cols [3];
    case (mask_mode_reg)
      MODE_CROSS:          wt = '{0, -1, 0, -1, 5, -1, 0, -1, 0};
      MODE_FULL:           wt = '{-1, -1, -1, -1, 9, -1, -1, -1, -1};
      MODE_DIAG:           wt = '{1, -2, 1, -2, 5, -2, 1, -2, 1};
      MODE_HP, MODE_HP_OFS: wt = '{-1, -1, -1, -1, 8, -1, -1, -1, -1};
      default:             return '0;
    endcase
    cols[0] = lft;
    cols[1] = ctr;
    cols[2] = rgt;
    acc = 0;
    for (int m = 0; m < 3; m++) begin
      for (int n = 0; n < 3; n++) begin
        acc += int'(cols[n][(2 - m) * PIX_W +: PIX_W]) * wt[m * 3 + n];
      end
    end
    if (mask_mode_reg == MODE_HP_OFS) acc += HP_OFFSET;
    if (mask_mode_reg == MODE_HP || mask_mode_reg == MODE_HP_OFS) begin
      // magnitudes truncate, non-negative values round half up
      q = (acc < 0) ? (-acc) / 9 : (2 * acc + 9) / 18;
    end else begin
      q = (acc < 0) ? -acc : acc;
    end
    return (q > PIX_MAX) ? PIX_W'(PIX_MAX) : PIX_W'(q);
  endfunction

  task automatic predict_pixel(input bit [PIX_W-1:0] pix, input bit drn);
    int               w, h, c, r;
    bit               row_end, drain_row;
    bit [PIX_W-1:0]   top, mid, bot;
    bit [3*PIX_W-1:0] fresh;
    pixel_result_t    res;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    c = col_pos;
    r = row_pos;
    row_end = (c + 1 >= w);
    drain_row = (r >= h);
    if (c >= MAX_WIDTH_DEF) c = MAX_WIDTH_DEF - 1;
    top = (r >= 2) ? line_two[c] : '0;
    mid = (r >= 1) ? line_one[c] : '0;
    bot = (drn || drain_row) ? '0 : pix;
    line_two[c] = line_one[c];
    line_one[c] = bot;
    if (c == 0) begin
      win_left = '0;
      win_ctr = '0;
    end
    fresh = {top, mid, bot};
    if (r >= 1) begin
      if (c >= 1) begin
        res.pix = filter_pixel(win_left, win_ctr, fresh);
        res.last = 1'b0;
        expected_pixels.push_back(res);
      end
      // right neighbors of the last column are zero padding
      if (row_end) begin
        res.pix = filter_pixel(win_ctr, fresh, '0);
        res.last = drain_row;
        expected_pixels.push_back(res);
      end
    end
    win_left = win_ctr;
    win_ctr = fresh;
    if (row_end) begin
      col_pos = 0;
      row_pos = drain_row ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // returns 1 when the item closes the frame
  function automatic bit push_item(input bit [PIX_W-1:0] pix, input bit drn);
    pixel_item_t it;
    bit          wrap;
    it.pix = pix;
    it.drain = drn;
    pending_pixels.push_back(it);
    queued_total++;
    wrap = 1'b0;
    if (gen_col + 1 >= eff_dim(width_reg)) begin
      wrap = (gen_row >= eff_dim(height_reg));
      gen_col = 0;
      gen_row = wrap ? 0 : gen_row + 1;
    end else begin
      gen_col++;
    end
    return wrap;
  endfunction

  // queues up to limit items of one texture, stopping at the end of a frame
  task automatic queue_items(input int limit);
    texture_t       texture;
    bit             done;
    bit             drn;
    bit [PIX_W-1:0] pix, base;
    texture = texture_t'($urandom_range(0, 2));
    base = $urandom_range(0, PIX_MAX - 3);
    done = 1'b0;
    for (int k = 0; k < limit && !done; k++) begin
      case (texture)
        TEXTURE_BINARY: pix = $urandom_range(0, 1) ? PIX_W'(PIX_MAX) : '0;
        TEXTURE_FLAT:   pix = base + $urandom_range(0, 3);
        default:        pix = $urandom_range(0, PIX_MAX);
      endcase
      drn = (gen_row >= eff_dim(height_reg));
      // a few misplaced drain flags
      if ($urandom_range(0, 24) == 0) drn = !drn;
      done = push_item(pix, drn);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MASK_MODE:    mask_mode_reg = data[MODE_W-1:0];
      CFG_IMAGE_WIDTH:  width_reg = data[DIM_W-1:0];
      CFG_IMAGE_HEIGHT: height_reg = data[DIM_W-1:0];
      default:          ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until every queued item is in and every result is out
  task automatic settle();
    while (pending_pixels.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
  endtask

  // sender
  always @(negedge clk) begin
    pixel_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_taken) in_wait = draw_wait(sender_steady);
      if (in_valid && !in_taken) begin
        // held while stalled
      end else if (in_wait > 0) begin
        in_wait--;
        in_valid <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
        it = pending_pixels.pop_front();
        in_valid <= 1'b1;
        in_pixel_in <= it.pix;
        in_drain <= it.drain;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_taken) out_wait = draw_wait(receiver_steady);
      if (out_wait > 0) begin
        out_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // acceptance, prediction, checking and watchdog
  always @(posedge clk) begin
    pixel_result_t want;
    in_taken <= rst_n && in_valid && !in_stall;
    out_taken <= rst_n && out_valid && !out_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_pixel(in_pixel_in, in_drain);
        items_in++;
      end
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_CAP)
            $error("unexpected result: pixel_out %0d last_pixel %0d",
                   out_pixel_out, out_last_pixel);
        end else begin
          want = expected_pixels.pop_front();
          results_seen++;
          if (want.last) frames_done++;
          if (out_pixel_out !== want.pix) begin
            fail_count++;
            if (fail_count <= REPORT_CAP)
              $error("pixel_out: expected %0d, got %0d", want.pix, out_pixel_out);
          end
          if (out_last_pixel !== want.last) begin
            fail_count++;
            if (fail_count <= REPORT_CAP)
              $error("last_pixel: expected %0d, got %0d", want.last, out_last_pixel);
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $error("no handshake for %0d cycles", quiet_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic [MODE_W-1:0] all_modes [8];
    int                phase;
    all_modes = '{MODE_CROSS, MODE_FULL, MODE_DIAG, MODE_HP, MODE_HP_OFS,
                  MODE_OFF, MODE_SPARE6, MODE_SPARE7};
    sender_steady = 1'b0;
    receiver_steady = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every mode on a single pixel frame at full scale
    set_geometry(CFG_DATA_W'(1), CFG_DATA_W'(1));
    foreach (all_modes[i]) begin
      write_reg(CFG_MASK_MODE, CFG_DATA_W'(all_modes[i]));
      void'(push_item(PIX_W'(PIX_MAX), 1'b0));
      void'(push_item(8'd37, 1'b1));
      settle();
    end

    // 3x2 high pass: negative sums, drain flag inside the image,
    // pixel item in the drain row
    write_reg(CFG_MASK_MODE, CFG_DATA_W'(MODE_HP));
    set_geometry(CFG_DATA_W'(3), CFG_DATA_W'(2));
    void'(push_item(8'd0, 1'b0));
    void'(push_item(PIX_W'(PIX_MAX), 1'b0));
    void'(push_item(8'd0, 1'b0));
    void'(push_item(PIX_W'(PIX_MAX), 1'b0));
    void'(push_item(8'd200, 1'b1));
    void'(push_item(PIX_W'(PIX_MAX), 1'b0));
    void'(push_item(8'd200, 1'b0));
    void'(push_item(8'd9, 1'b1));
    void'(push_item(8'd0, 1'b1));
    settle();

    for (phase = 0; queued_total < ITEM_TARGET; phase++) begin
      sender_steady = ($urandom_range(0, 4) == 0);
      receiver_steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_MASK_MODE, CFG_DATA_W'($urandom_range(0, (1 << MODE_W) - 1)));
      else
        write_reg(CFG_MASK_MODE, CFG_DATA_W'($urandom_range(MODE_CROSS, MODE_HP_OFS)));
      case (phase)
        1: begin
          // widest row, width register past the maximum; the drain row
          // then runs at a narrow width
          set_geometry('1, CFG_DATA_W'(1));
          queue_items(MAX_WIDTH_DEF);
          settle();
          set_geometry(CFG_DATA_W'(3), CFG_DATA_W'(1));
          queue_items(WHOLE_FRAME);
        end
        2: begin
          // zero width acts as one column
          set_geometry('0, CFG_DATA_W'(40));
          queue_items(WHOLE_FRAME);
        end
        3: begin
          // shrink the frame mid image: column past the new last one ends
          // the row and the current row becomes the drain row
          set_geometry(CFG_DATA_W'(7), CFG_DATA_W'(5));
          queue_items(17);
          settle();
          set_geometry(CFG_DATA_W'(3), CFG_DATA_W'(2));
          queue_items(WHOLE_FRAME);
          queue_items(WHOLE_FRAME);
        end
        default: begin
          set_geometry(($urandom_range(0, 11) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 9)),
                       ($urandom_range(0, 11) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 6)));
          repeat ($urandom_range(1, 3)) queue_items(WHOLE_FRAME);
        end
      endcase
      settle();
    end

    $display("%0d items in, %0d filtered pixels checked over %0d frames", items_in,
             results_seen, frames_done);
    $display("all eight mode values, frames up to 9x6 and 1x40, one row 512 wide");
    if (fail_count == 0 && expected_pixels.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
